// ===== rtl/mex_pkg.sv =====
// shared types, opcodes and constants for the mips execute unit
// no dependencies
`default_nettype none
package mex_pkg;

  localparam int CNT_W           = 6;
  localparam int CNT_MAX         = 63;
  localparam int MUL_LATENCY_DEF = 4;
  localparam int DIV_LATENCY_DEF = 32;
  localparam int IN_DATA_W       = 136;
  localparam int OUT_DATA_W      = 136;

  // primary opcodes
  localparam logic [5:0] OP_SPCL    = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIMMU = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIMMU = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // funct codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // regimm rt codes
  localparam logic [5:0] RT_BLTZ   = 6'h00;
  localparam logic [5:0] RT_BGEZ   = 6'h01;
  localparam logic [5:0] RT_BLTZAL = 6'h10;
  localparam logic [5:0] RT_BGEZAL = 6'h11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_finish;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic start_mul;
    logic start_div;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/mex_ctrl.sv =====
// controller state machine for the mips execute unit
// depends on mex_pkg
`default_nettype none
module mex_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  mex_pkg::status_t status,
  output mex_pkg::cmd_t    cmd
);

  mex_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mex_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mex_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.start_mul) state_next = mex_pkg::ST_MUL;
          else if (status.start_div) state_next = mex_pkg::ST_DIV;
          else state_next = mex_pkg::ST_OUT;
        end
      end
      mex_pkg::ST_MUL: state_next = mex_pkg::ST_OUT;
      mex_pkg::ST_DIV: begin
        if (status.div_last) state_next = mex_pkg::ST_OUT;
      end
      mex_pkg::ST_OUT: begin
        if (out_ready) state_next = mex_pkg::ST_IDLE;
      end
      default: state_next = mex_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == mex_pkg::ST_IDLE);
    out_valid      = (state == mex_pkg::ST_OUT);
    cmd.accept     = in_ready && in_valid;
    cmd.mul_finish = (state == mex_pkg::ST_MUL);
    cmd.div_step   = (state == mex_pkg::ST_DIV);
  end

endmodule
`default_nettype wire

// ===== rtl/mex_dp.sv =====
// datapath of the mips execute unit: alu, branch unit, hi/lo, busy counter,
// multiplier and bit-serial divider; depends on mex_pkg
`default_nettype none
module mex_dp #(
  parameter int MUL_LATENCY = mex_pkg::MUL_LATENCY_DEF,
  parameter int DIV_LATENCY = mex_pkg::DIV_LATENCY_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               op_valid,
  input  wire  [5:0]        mode,
  input  wire  [5:0]        sub_mode,
  input  wire  [31:0]       src1_value,
  input  wire  [31:0]       src2_value,
  input  wire  [4:0]        shift_amount,
  input  wire  [15:0]       immediate,
  input  wire  [31:0]       inst_address,
  input  mex_pkg::cmd_t     cmd,
  output mex_pkg::status_t  status,
  output logic              held,
  output logic [31:0]       dest_value,
  output logic [31:0]       mem_address,
  output logic [31:0]       store_data,
  output logic              fetch_redirect,
  output logic [31:0]       branch_target
);

  localparam logic [mex_pkg::CNT_W-1:0] MulLoad = (MUL_LATENCY > mex_pkg::CNT_MAX) ?
    mex_pkg::CNT_W'(mex_pkg::CNT_MAX) : mex_pkg::CNT_W'(MUL_LATENCY);
  localparam logic [mex_pkg::CNT_W-1:0] DivLoad = (DIV_LATENCY > mex_pkg::CNT_MAX) ?
    mex_pkg::CNT_W'(mex_pkg::CNT_MAX) : mex_pkg::CNT_W'(DIV_LATENCY);

  logic [31:0] hi_reg, lo_reg;
  logic [mex_pkg::CNT_W-1:0] busy_count, busy_dec;

  // multiplier operands
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_prod;

  // divider
  logic [31:0] div_rem, div_quo, div_mb;
  logic [4:0]  div_cnt;
  logic        div_qneg, div_rneg, div_zero;
  logic [32:0] div_shift, div_diff;
  logic        div_ge;
  logic [31:0] div_rem_next, div_quo_next;

  // decode
  logic [31:0] a, b, se, link, btgt;
  logic [4:0]  vsh;
  logic        is_special, mf_busy, is_mult, is_div, is_signed;
  logic        r_held, r_taken;
  logic [31:0] r_dest, r_maddr, r_sdata, r_tgt;
  logic        wr_hi, wr_lo;
  logic        na, nb;

  assign a    = src1_value;
  assign b    = src2_value;
  assign se   = {{16{immediate[15]}}, immediate};
  assign link = inst_address + 32'd4;
  assign btgt = inst_address + 32'd4 + {se[29:0], 2'b00};
  assign vsh  = a[4:0];
  assign busy_dec = (busy_count != '0) ? busy_count - 1'b1 : busy_count;
  assign mf_busy  = (busy_dec != '0);
  assign is_special = op_valid && (mode == mex_pkg::OP_SPCL);
  assign is_mult = is_special &&
    (sub_mode == mex_pkg::FN_MULT || sub_mode == mex_pkg::FN_MULTU);
  assign is_div = is_special &&
    (sub_mode == mex_pkg::FN_DIV || sub_mode == mex_pkg::FN_DIVU);
  assign is_signed = (sub_mode == mex_pkg::FN_MULT || sub_mode == mex_pkg::FN_DIV);
  assign na = is_signed && a[31];
  assign nb = is_signed && b[31];

  always_comb begin
    r_held  = 1'b0;
    r_dest  = '0;
    r_maddr = '0;
    r_sdata = '0;
    r_taken = 1'b0;
    r_tgt   = '0;
    wr_hi   = 1'b0;
    wr_lo   = 1'b0;
    if (op_valid) begin
      unique case (mode)
        mex_pkg::OP_SPCL: begin
          unique case (sub_mode)
            mex_pkg::FN_SLL:  r_dest = b << shift_amount;
            mex_pkg::FN_SRL:  r_dest = b >> shift_amount;
            mex_pkg::FN_SRA:  r_dest = 32'($signed(b) >>> shift_amount);
            mex_pkg::FN_SLLV: r_dest = b << vsh;
            mex_pkg::FN_SRLV: r_dest = b >> vsh;
            mex_pkg::FN_SRAV: r_dest = 32'($signed(b) >>> vsh);
            mex_pkg::FN_JR, mex_pkg::FN_JALR: begin
              r_dest = link; r_tgt = a; r_taken = 1'b1;
            end
            mex_pkg::FN_MFHI: begin
              if (mf_busy) r_held = 1'b1;
              else r_dest = hi_reg;
            end
            mex_pkg::FN_MTHI: begin
              if (mf_busy) r_held = 1'b1;
              else wr_hi = 1'b1;
            end
            mex_pkg::FN_MFLO: begin
              if (mf_busy) r_held = 1'b1;
              else r_dest = lo_reg;
            end
            mex_pkg::FN_MTLO: begin
              if (mf_busy) r_held = 1'b1;
              else wr_lo = 1'b1;
            end
            mex_pkg::FN_ADD, mex_pkg::FN_ADDU: r_dest = a + b;
            mex_pkg::FN_SUB, mex_pkg::FN_SUBU: r_dest = a - b;
            mex_pkg::FN_AND: r_dest = a & b;
            mex_pkg::FN_OR:  r_dest = a | b;
            mex_pkg::FN_XOR: r_dest = a ^ b;
            mex_pkg::FN_NOR: r_dest = ~(a | b);
            mex_pkg::FN_SLT: r_dest = {31'd0, $signed(a) < $signed(b)};
            mex_pkg::FN_SLTU: r_dest = {31'd0, a < b};
            default: ;
          endcase
        end
        mex_pkg::OP_REGIMM: begin
          unique case (sub_mode)
            mex_pkg::RT_BLTZ: begin r_tgt = btgt; r_taken = a[31]; end
            mex_pkg::RT_BGEZ: begin r_tgt = btgt; r_taken = !a[31]; end
            mex_pkg::RT_BLTZAL: begin
              r_tgt = btgt; r_dest = link; r_taken = a[31];
            end
            mex_pkg::RT_BGEZAL: begin
              r_tgt = btgt; r_dest = link; r_taken = !a[31];
            end
            default: ;
          endcase
        end
        mex_pkg::OP_BEQ:  begin r_tgt = btgt; r_taken = (a == b); end
        mex_pkg::OP_BNE:  begin r_tgt = btgt; r_taken = (a != b); end
        mex_pkg::OP_BLEZ: begin r_tgt = btgt; r_taken = a[31] || (a == '0); end
        mex_pkg::OP_BGTZ: begin r_tgt = btgt; r_taken = !a[31] && (a != '0); end
        mex_pkg::OP_ADDI, mex_pkg::OP_ADDIMMU: r_dest = a + se;
        mex_pkg::OP_SLTI:  r_dest = {31'd0, $signed(a) < $signed(se)};
        mex_pkg::OP_SLTIMMU: r_dest = {31'd0, a < se};
        mex_pkg::OP_ANDI:  r_dest = a & {16'd0, immediate};
        mex_pkg::OP_ORI:   r_dest = a | {16'd0, immediate};
        mex_pkg::OP_XORI:  r_dest = a ^ {16'd0, immediate};
        mex_pkg::OP_LUI:   r_dest = {immediate, 16'd0};
        mex_pkg::OP_LB, mex_pkg::OP_LH, mex_pkg::OP_LW, mex_pkg::OP_LBU,
        mex_pkg::OP_LHU: r_maddr = a + se;
        mex_pkg::OP_SB, mex_pkg::OP_SH, mex_pkg::OP_SW: begin
          r_maddr = a + se; r_sdata = b;
        end
        default: ;
      endcase
    end
  end

  assign status.start_mul = is_mult;
  assign status.start_div = is_div;
  assign status.div_last  = (div_cnt == 5'd31);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held           <= r_held;
      dest_value     <= r_dest;
      mem_address    <= r_maddr;
      store_data     <= r_sdata;
      fetch_redirect <= r_taken;
      branch_target  <= r_tgt;
    end
  end

  // one signed 33x33 product covers both signed and unsigned forms
  assign mul_prod = 66'($signed(mul_a) * $signed(mul_b));

  // restoring divider step on magnitudes
  assign div_shift    = {div_rem, div_quo[31]};
  assign div_diff     = div_shift - {1'b0, div_mb};
  assign div_ge       = !div_diff[32];
  assign div_rem_next = div_ge ? div_diff[31:0] : div_shift[31:0];
  assign div_quo_next = {div_quo[30:0], div_ge};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mul_a    <= {na, a};
      mul_b    <= {nb, b};
      div_rem  <= '0;
      div_quo  <= na ? 32'(-a) : a;
      div_mb   <= nb ? 32'(-b) : b;
      div_qneg <= na ^ nb;
      div_rneg <= na;
      div_zero <= (b == '0);
    end else if (cmd.div_step) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_reg     <= '0;
      lo_reg     <= '0;
      busy_count <= '0;
      div_cnt    <= '0;
    end else begin
      if (cmd.accept) begin
        div_cnt <= '0;
        if (is_mult) busy_count <= MulLoad;
        else if (is_div) busy_count <= DivLoad;
        else busy_count <= busy_dec;
        if (wr_hi) hi_reg <= a;
        if (wr_lo) lo_reg <= a;
      end
      if (cmd.mul_finish) begin
        hi_reg <= mul_prod[63:32];
        lo_reg <= mul_prod[31:0];
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 5'd1;
        if (status.div_last) begin
          if (div_zero) begin
            hi_reg <= '0;
            lo_reg <= '0;
          end else begin
            lo_reg <= div_qneg ? 32'(-div_quo_next) : div_quo_next;
            hi_reg <= div_rneg ? 32'(-div_rem_next) : div_rem_next;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mips_execute_unit_hilo.sv =====
// mips32 execute stage with hi/lo multiply/divide: top level
// a beat is accepted and registered; alu, branch and hi/lo move results are
// offered in the next cycle, mult/multu after the multiply state and div/divu
// after the divide steps (one quotient bit per cycle in the bit-serial divider)
// one beat in flight: next beat taken the cycle after the result is taken
// synchronous active-high reset clears hi, lo, the busy counter and the fsm
// depends on mex_pkg, mex_ctrl, mex_dp
`default_nettype none
module mips_execute_unit_hilo #(
  parameter int MUL_LATENCY = mex_pkg::MUL_LATENCY_DEF,
  parameter int DIV_LATENCY = mex_pkg::DIV_LATENCY_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // mode, sub_mode, src1_value, src2_value, shift_amount, immediate,
  // inst_address, zero pad
  input  wire  [mex_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op_valid
  input  wire                              s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // dest_value, mem_address, store_data, fetch_redirect, branch_target, zero pad
  output logic [mex_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // held
  output logic                             m_axis_tuser
);

  mex_pkg::cmd_t    cmd;
  mex_pkg::status_t status;

  logic        held, fetch_redirect;
  logic [31:0] dest_value, mem_address, store_data, branch_target;

  // controller: sequences accept, multiply finish, divide steps and result beat
  mex_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: unpack beat fields straight from tdata
  mex_dp #(
    .MUL_LATENCY (MUL_LATENCY),
    .DIV_LATENCY (DIV_LATENCY)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (s_axis_tuser),
    .mode           (s_axis_tdata[5:0]),
    .sub_mode       (s_axis_tdata[11:6]),
    .src1_value     (s_axis_tdata[43:12]),
    .src2_value     (s_axis_tdata[75:44]),
    .shift_amount   (s_axis_tdata[80:76]),
    .immediate      (s_axis_tdata[96:81]),
    .inst_address   (s_axis_tdata[128:97]),
    .cmd            (cmd),
    .status         (status),
    .held           (held),
    .dest_value     (dest_value),
    .mem_address    (mem_address),
    .store_data     (store_data),
    .fetch_redirect (fetch_redirect),
    .branch_target  (branch_target)
  );

  // pack the result beat
  assign m_axis_tuser = held;
  assign m_axis_tdata = {7'd0, branch_target, fetch_redirect, store_data,
                         mem_address, dest_value};

endmodule
`default_nettype wire

// ===== rtl/mex_checker.sv =====
// port-level checker for the mips execute unit, bound to the top level
// depends on nothing but the top level's ports
`default_nettype none
module mex_checker (
  input wire         clk,
  input wire         rst,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [135:0] m_axis_tdata,
  input wire         m_axis_tuser
);

  // a waiting result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // one beat in flight: never ready while a result is offered
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // an accepted beat closes the input right after its accept
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input reopened right after accept");

  // a held move carries no other result
  a_held_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("held beat with nonzero fields");

endmodule

bind mips_execute_unit_hilo mex_checker u_mex_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== tb/mips_execute_unit_hilo_tb.sv =====
// testbench for the mips32 execute stage with hi/lo multiply/divide unit
// drives operation beats through the stream ports and checks every result
// against an in-bench model of the stage; depends on mex_pkg and the rtl
`timescale 1ns / 1ps
`default_nettype none
module mips_execute_unit_hilo_tb;

  // one decoded operation as it enters the stage
  typedef struct {
    logic        op_valid;
    logic [5:0]  mode;
    logic [5:0]  sub_mode;
    logic [31:0] src1;
    logic [31:0] src2;
    logic [4:0]  shamt;
    logic [15:0] imm;
    logic [31:0] pc;
  } exop_t;

  // one stage result
  typedef struct {
    logic        held;
    logic [31:0] dest;
    logic [31:0] maddr;
    logic [31:0] sdata;
    logic        taken;
    logic [31:0] target;
  } exres_t;

  // model of the stage: hi, lo and the busy counter, plus the queue of
  // results still owed by the block
  class exec_scoreboard;
    logic [31:0] hi_q, lo_q;
    int unsigned busy;
    exres_t      owed[$];
    int          errors, n_in, n_out, n_held;

    function new();
      hi_q = '0; lo_q = '0; busy = 0;
      errors = 0; n_in = 0; n_out = 0; n_held = 0;
    endfunction

    function automatic exres_t execute(exop_t op);
      exres_t      r;
      logic [31:0] a, b, se, link, btgt, ma, mb, q, rm;
      logic [63:0] p;
      logic        na, nb;
      a = op.src1; b = op.src2;
      se = {{16{op.imm[15]}}, op.imm};
      link = op.pc + 32'd4;
      btgt = op.pc + 32'd4 + (se << 2);
      r = '{default: '0};
      if (busy > 0) busy--;
      if (!op.op_valid) return r;
      case (op.mode)
        mex_pkg::OP_SPCL: begin
          case (op.sub_mode)
            mex_pkg::FN_SLL:  r.dest = b << op.shamt;
            mex_pkg::FN_SRL:  r.dest = b >> op.shamt;
            mex_pkg::FN_SRA:  r.dest = $signed(b) >>> op.shamt;
            mex_pkg::FN_SLLV: r.dest = b << a[4:0];
            mex_pkg::FN_SRLV: r.dest = b >> a[4:0];
            mex_pkg::FN_SRAV: r.dest = $signed(b) >>> a[4:0];
            mex_pkg::FN_JR, mex_pkg::FN_JALR: begin
              r.dest = link; r.target = a; r.taken = 1'b1;
            end
            mex_pkg::FN_MFHI, mex_pkg::FN_MTHI, mex_pkg::FN_MFLO,
            mex_pkg::FN_MTLO: begin
              // moves wait while the multiply/divide counter is still running
              if (busy > 0) r.held = 1'b1;
              else if (op.sub_mode == mex_pkg::FN_MFHI) r.dest = hi_q;
              else if (op.sub_mode == mex_pkg::FN_MTHI) hi_q = a;
              else if (op.sub_mode == mex_pkg::FN_MFLO) r.dest = lo_q;
              else lo_q = a;
            end
            mex_pkg::FN_MULT, mex_pkg::FN_MULTU: begin
              if (op.sub_mode == mex_pkg::FN_MULT) p = $signed(a) * $signed(b);
              else p = {32'd0, a} * {32'd0, b};
              hi_q = p[63:32]; lo_q = p[31:0];
              busy = mex_pkg::MUL_LATENCY_DEF;
            end
            mex_pkg::FN_DIV, mex_pkg::FN_DIVU: begin
              if (b == 0) begin
                hi_q = '0; lo_q = '0;
              end else if (op.sub_mode == mex_pkg::FN_DIVU) begin
                lo_q = a / b; hi_q = a % b;
              end else begin
                // magnitudes, then signs; int_min / -1 wraps to int_min
                na = a[31]; nb = b[31];
                ma = na ? -a : a;
                mb = nb ? -b : b;
                q = ma / mb; rm = ma % mb;
                lo_q = (na != nb) ? -q : q;
                hi_q = na ? -rm : rm;
              end
              busy = mex_pkg::DIV_LATENCY_DEF;
            end
            mex_pkg::FN_ADD, mex_pkg::FN_ADDU: r.dest = a + b;
            mex_pkg::FN_SUB, mex_pkg::FN_SUBU: r.dest = a - b;
            mex_pkg::FN_AND:  r.dest = a & b;
            mex_pkg::FN_OR:   r.dest = a | b;
            mex_pkg::FN_XOR:  r.dest = a ^ b;
            mex_pkg::FN_NOR:  r.dest = ~(a | b);
            mex_pkg::FN_SLT:  r.dest = {31'd0, $signed(a) < $signed(b)};
            mex_pkg::FN_SLTU: r.dest = {31'd0, a < b};
            default: ;
          endcase
        end
        mex_pkg::OP_REGIMM: begin
          case (op.sub_mode)
            mex_pkg::RT_BLTZ: begin r.target = btgt; r.taken = a[31]; end
            mex_pkg::RT_BGEZ: begin r.target = btgt; r.taken = !a[31]; end
            mex_pkg::RT_BLTZAL: begin
              r.target = btgt; r.dest = link; r.taken = a[31];
            end
            mex_pkg::RT_BGEZAL: begin
              r.target = btgt; r.dest = link; r.taken = !a[31];
            end
            default: ;
          endcase
        end
        mex_pkg::OP_BEQ:  begin r.target = btgt; r.taken = (a == b); end
        mex_pkg::OP_BNE:  begin r.target = btgt; r.taken = (a != b); end
        mex_pkg::OP_BLEZ: begin r.target = btgt; r.taken = a[31] || a == 0; end
        mex_pkg::OP_BGTZ: begin r.target = btgt; r.taken = !a[31] && a != 0; end
        mex_pkg::OP_ADDI, mex_pkg::OP_ADDIMMU: r.dest = a + se;
        mex_pkg::OP_SLTI:    r.dest = {31'd0, $signed(a) < $signed(se)};
        mex_pkg::OP_SLTIMMU: r.dest = {31'd0, a < se};
        mex_pkg::OP_ANDI:    r.dest = a & {16'd0, op.imm};
        mex_pkg::OP_ORI:     r.dest = a | {16'd0, op.imm};
        mex_pkg::OP_XORI:    r.dest = a ^ {16'd0, op.imm};
        mex_pkg::OP_LUI:     r.dest = {op.imm, 16'd0};
        mex_pkg::OP_LB, mex_pkg::OP_LH, mex_pkg::OP_LW, mex_pkg::OP_LBU,
        mex_pkg::OP_LHU: r.maddr = a + se;
        mex_pkg::OP_SB, mex_pkg::OP_SH, mex_pkg::OP_SW: begin
          r.maddr = a + se; r.sdata = b;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(exop_t op);
      owed.push_back(execute(op));
      n_in++;
    endfunction

    function void check_result(exres_t got);
      exres_t w;
      n_out++;
      if (owed.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      w = owed.pop_front();
      if (w.held) n_held++;
      if (got.held !== w.held) begin
        $error("held: expected %0h got %0h", w.held, got.held); errors++;
      end
      if (got.dest !== w.dest) begin
        $error("dest_value: expected %h got %h", w.dest, got.dest); errors++;
      end
      if (got.maddr !== w.maddr) begin
        $error("mem_address: expected %h got %h", w.maddr, got.maddr); errors++;
      end
      if (got.sdata !== w.sdata) begin
        $error("store_data: expected %h got %h", w.sdata, got.sdata); errors++;
      end
      if (got.taken !== w.taken) begin
        $error("fetch_redirect: expected %0h got %0h", w.taken, got.taken);
        errors++;
      end
      if (got.target !== w.target) begin
        $error("branch_target: expected %h got %h", w.target, got.target); errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [mex_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [mex_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;

  exec_scoreboard sb;
  int snd_idle_pct;   // chance in a hundred that the sender idles before a beat
  int rcv_idle_pct;   // chance in a hundred that the receiver stalls a cycle
  int hold_request;   // long receiver hold-off asked for by the stimulus

  mips_execute_unit_hilo DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver: random stalls, plus one long hold-off counted here
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // result monitor; values read at the edge are those before the update
  always @(posedge clk) begin
    exres_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.dest   = m_axis_tdata[31:0];
      got.maddr  = m_axis_tdata[63:32];
      got.sdata  = m_axis_tdata[95:64];
      got.taken  = m_axis_tdata[96];
      got.target = m_axis_tdata[128:97];
      got.held   = m_axis_tuser;
      sb.check_result(got);
    end
  end

  // present one beat and wait for the edge that takes it
  task automatic send_op(exop_t op);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.op_valid;
    // tdata from bit 0: mode, sub_mode, rs, rt, shamt, immediate, pc, pad
    s_axis_tdata  <= {7'd0, op.pc, op.imm, op.shamt, op.src2, op.src1,
                      op.sub_mode, op.mode};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  function automatic exop_t mk(logic [5:0] mode, logic [5:0] sub_mode,
                               logic [31:0] a, logic [31:0] b,
                               logic [4:0] sh, logic [15:0] imm);
    exop_t op;
    op.op_valid = 1'b1; op.mode = mode; op.sub_mode = sub_mode;
    op.src1 = a; op.src2 = b; op.shamt = sh; op.imm = imm;
    op.pc = $urandom();
    return op;
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic exop_t rnd_op();
    logic [5:0] r_ops[$] = '{mex_pkg::FN_SLL, mex_pkg::FN_SRL, mex_pkg::FN_SRA,
      mex_pkg::FN_SLLV, mex_pkg::FN_SRLV, mex_pkg::FN_SRAV, mex_pkg::FN_JR,
      mex_pkg::FN_JALR, mex_pkg::FN_ADD, mex_pkg::FN_ADDU, mex_pkg::FN_SUB,
      mex_pkg::FN_SUBU, mex_pkg::FN_AND, mex_pkg::FN_OR, mex_pkg::FN_XOR,
      mex_pkg::FN_NOR, mex_pkg::FN_SLT, mex_pkg::FN_SLTU};
    logic [5:0] i_ops[$] = '{mex_pkg::OP_BEQ, mex_pkg::OP_BNE, mex_pkg::OP_BLEZ,
      mex_pkg::OP_BGTZ, mex_pkg::OP_ADDI, mex_pkg::OP_ADDIMMU, mex_pkg::OP_SLTI,
      mex_pkg::OP_SLTIMMU, mex_pkg::OP_ANDI, mex_pkg::OP_ORI, mex_pkg::OP_XORI,
      mex_pkg::OP_LUI, mex_pkg::OP_LB, mex_pkg::OP_LH, mex_pkg::OP_LW,
      mex_pkg::OP_LBU, mex_pkg::OP_LHU, mex_pkg::OP_SB, mex_pkg::OP_SH,
      mex_pkg::OP_SW};
    logic [5:0] hl_ops[$] = '{mex_pkg::FN_MFHI, mex_pkg::FN_MTHI, mex_pkg::FN_MFLO,
      mex_pkg::FN_MTLO};
    logic [5:0] md_ops[$] = '{mex_pkg::FN_MULT, mex_pkg::FN_MULTU, mex_pkg::FN_DIV,
      mex_pkg::FN_DIVU};
    logic [5:0] rt_ops[$] = '{mex_pkg::RT_BLTZ, mex_pkg::RT_BGEZ, mex_pkg::RT_BLTZAL,
      mex_pkg::RT_BGEZAL};
    exop_t op;
    int    pick;
    op = mk(6'($urandom()), 6'($urandom()), rnd_word(), rnd_word(),
            5'($urandom()), 16'($urandom()));
    pick = $urandom_range(99);
    if (pick < 5) op.op_valid = 1'b0;                   // bubble, junk fields
    else if (pick < 15) begin
      op.mode = mex_pkg::OP_SPCL; op.sub_mode = md_ops[$urandom_range(3)];
      if ($urandom_range(5) == 0) op.src2 = '0;         // divide by zero
    end else if (pick < 33) begin
      op.mode = mex_pkg::OP_SPCL; op.sub_mode = hl_ops[$urandom_range(3)];
    end else if (pick < 58) begin
      op.mode = mex_pkg::OP_SPCL;
      op.sub_mode = r_ops[$urandom_range(r_ops.size()-1)];
      if ($urandom_range(3) == 0) op.src2 = op.src1;    // equal operands
    end else if (pick < 88) begin
      op.mode = i_ops[$urandom_range(i_ops.size()-1)];
      if ($urandom_range(3) == 0) op.src2 = op.src1;
    end else if (pick < 94) begin
      op.mode = mex_pkg::OP_REGIMM; op.sub_mode = rt_ops[$urandom_range(3)];
    end
    // the rest keep fully random opcode and funct, unknown codes among them
    return op;
  endfunction

  initial begin
    #20_000_000;
    $display("timed out with %0d results outstanding", sb.owed.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    exop_t op;
    int    phase;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_request = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, each special case of the stage
    snd_idle_pct = 14; rcv_idle_pct = 61;
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_ADD, 32'hFFFF_FFFF, 32'h0000_0001,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_SUB, 32'h8000_0000, 32'h0000_0001,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_SLL, 32'd0, 32'hFFFF_FFFF,
            5'd31, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_SRAV, 32'hFFFF_FFE4, 32'h8000_0000,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_SRLV, 32'h0000_0020, 32'hFFFF_FFFF,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_SLT, 32'h8000_0000, 32'h7FFF_FFFF,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_MTHI, 32'hDEAD_BEEF, 32'd0,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_MTLO, 32'h1234_5678, 32'd0,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_MFHI, 32'd0, 32'd0,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_MULT, 32'h8000_0000, 32'hFFFF_FFFF,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_MFLO, 32'd0, 32'd0,
            5'd0, 16'd0); send_op(op);                               // held
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_MTHI, 32'h5555_5555, 32'd0,
            5'd0, 16'd0); send_op(op);                               // held
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_DIVU, 32'hFFFF_FFFF, 32'd0,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_SPCL, mex_pkg::FN_JALR, 32'hFFFF_FFFC, 32'd0,
            5'd0, 16'd0); send_op(op);
    op = mk(mex_pkg::OP_REGIMM, mex_pkg::RT_BLTZAL, 32'h8000_0000, 32'd0,
            5'd0, 16'h8000); send_op(op);
    op = mk(mex_pkg::OP_REGIMM, 6'h3F, 32'h8000_0000, 32'd0,
            5'd0, 16'h7FFF); send_op(op);
    op = mk(mex_pkg::OP_BLEZ, 6'd0, 32'd0, 32'd0, 5'd0, 16'hFFFF); send_op(op);
    op = mk(mex_pkg::OP_SLTIMMU, 6'd0, 32'h0000_0001, 32'd0,
            5'd0, 16'hFFFF); send_op(op);
    op = mk(mex_pkg::OP_LUI, 6'd0, 32'd0, 32'd0, 5'd0, 16'hFFFF); send_op(op);
    op = mk(mex_pkg::OP_SW, 6'd0, 32'h0000_0000, 32'hFFFF_FFFF,
            5'd0, 16'h8000); send_op(op);
    op = mk(6'h02, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            5'd0, 16'd0); send_op(op);                               // jump
    op = mk(mex_pkg::OP_SPCL, 6'h0C, 32'hFFFF_FFFF, 32'd0,
            5'd0, 16'd0); send_op(op);                               // syscall
    op = mk(mex_pkg::OP_ADDI, 6'd0, 32'd0, 32'd0, 5'd0, 16'd0);
    op.op_valid = 1'b0; send_op(op);                                 // bubble
    drain();

    // random: three idling regimes, with a long receiver hold-off in the first
    for (phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 61 : 0;
      rcv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 14 : 0;
      for (int i = 0; i < 580; i++) begin
        if (phase == 0 && i == 100) hold_request = 300;
        // pause the sender until every outstanding result is back
        if (phase == 1 && i == 200) drain();
        send_op(rnd_op());
      end
    end
    drain();
    repeat (40) @(posedge clk);

    $display("ran %0d operation beats and checked %0d results, %0d of them held moves",
             sb.n_in, sb.n_out, sb.n_held);
    $display("covered alu, shift, branch, load/store and hi/lo mult/div under stalls");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/mex_pkg.sv
rtl/mex_ctrl.sv
rtl/mex_dp.sv
rtl/mips_execute_unit_hilo.sv
rtl/mex_checker.sv
tb/mips_execute_unit_hilo_tb.sv
